// ===== hdl/sign_partition_two_pointer_defines.svh =====
// Assertion macros shared by the checker of sign_partition_two_pointer.
// No dependencies; include guard below.
`ifndef SIGN_PARTITION_TWO_POINTER_DEFINES_SVH
`define SIGN_PARTITION_TWO_POINTER_DEFINES_SVH

// Concurrent check, disabled while reset is high.
`define SPART_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("spart check failed");

// Concurrent check that also runs through reset.
`define SPART_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("spart reset check failed");

`endif

// ===== hdl/spart_pkg.sv =====
// Package for sign_partition_two_pointer: value width and sequencer states.
// No dependencies.
`default_nettype none

package spart_pkg;

  localparam int VALUE_W  = 32;
  localparam int SIGN_BIT = VALUE_W - 1;

  typedef enum logic [3:0] {
    ST_COLLECT,
    ST_INIT_LO,
    ST_INIT_HI,
    ST_INIT_RD,
    ST_TEST,
    ST_STEP_HI,
    ST_RD_HI,
    ST_SWAP_LO,
    ST_SWAP_HI,
    ST_STEP_LO,
    ST_RD_LO,
    ST_EMIT_LOAD,
    ST_EMIT_HOLD
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/sign_partition_two_pointer.sv =====
// Channel   Signals                                   Role
// item      item_valid, item_stall, value, last_in   elements in, one beat each
// result    result_valid, result_stall,              partitioned set out
//           result_value, last_out
//
// Loading takes one beat per cycle into a single-port-write, registered-read RAM.
// On the last beat, setup runs states ST_INIT_LO, ST_INIT_HI, ST_INIT_RD; then each
// pointer step runs test, high step, swap check and low step, with a RAM read state
// after each pointer move and a second write state for a swap, then a final test.
// Output: each result beat passes ST_EMIT_LOAD and ST_EMIT_HOLD, held while stalled;
// a new set is taken after the last result beat. Reset clears control only; the RAM
// needs no clearing pass. Depends on spart_pkg.
`default_nettype none

module sign_partition_two_pointer #(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic signed [spart_pkg::VALUE_W-1:0] value,
  input  logic                                last_in,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic signed [spart_pkg::VALUE_W-1:0] result_value,
  output logic                                last_out
);
  import spart_pkg::*;

  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ELEMENTS);

  logic [VALUE_W-1:0] ram [MAX_ELEMENTS];
  logic [VALUE_W-1:0] rdata;

  state_t state, state_next;

  logic [CW-1:0] count;
  logic [CW-1:0] lo;
  logic [CW-1:0] hi;
  logic [AW-1:0] k;
  logic [VALUE_W-1:0] val_lo;
  logic [VALUE_W-1:0] val_hi;

  logic [CW-1:0] count_m1;
  logic [CW-1:0] hi_m1;
  logic [CW-1:0] lo_p1;
  logic [AW-1:0] k_p1;
  logic          swap;
  logic          item_beat;
  logic          result_beat;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [VALUE_W-1:0] wdata;
  logic [AW-1:0]      raddr;

  assign count_m1    = count - 1'b1;
  assign hi_m1       = hi - 1'b1;
  assign lo_p1       = lo + 1'b1;
  assign k_p1        = k + 1'b1;
  assign swap        = val_hi[SIGN_BIT] && !val_lo[SIGN_BIT];
  assign item_beat   = item_valid && !item_stall;
  assign result_beat = result_valid && !result_stall;

  // RAM: one write, one registered read. A read issued in a write cycle is never
  // consumed, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (we) begin
      ram[waddr] <= wdata;
    end
    rdata <= ram[raddr];
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_COLLECT:   if (item_valid && last_in) state_next = ST_INIT_LO;
      ST_INIT_LO:   state_next = ST_INIT_HI;
      ST_INIT_HI:   state_next = ST_INIT_RD;
      ST_INIT_RD:   state_next = ST_TEST;
      ST_TEST:      state_next = (lo < hi) ? ST_STEP_HI : ST_EMIT_LOAD;
      ST_STEP_HI:   state_next = val_hi[SIGN_BIT] ? ST_SWAP_LO : ST_RD_HI;
      ST_RD_HI:     state_next = ST_SWAP_LO;
      ST_SWAP_LO:   state_next = swap ? ST_SWAP_HI : ST_STEP_LO;
      ST_SWAP_HI:   state_next = ST_STEP_LO;
      ST_STEP_LO:   state_next = val_lo[SIGN_BIT] ? ST_RD_LO : ST_TEST;
      ST_RD_LO:     state_next = ST_TEST;
      ST_EMIT_LOAD: state_next = ST_EMIT_HOLD;
      ST_EMIT_HOLD: begin
        if (result_beat) begin
          state_next = last_out ? ST_COLLECT : ST_EMIT_LOAD;
        end
      end
      default:      state_next = ST_COLLECT;
    endcase
  end

  always_comb begin
    item_stall = 1'b1;
    we         = 1'b0;
    waddr      = count[AW-1:0];
    wdata      = value;
    raddr      = '0;
    case (state)
      ST_COLLECT: begin
        item_stall = 1'b0;
        we         = item_valid && (count < MAX_CNT);
      end
      ST_INIT_HI:   raddr = count_m1[AW-1:0];
      ST_STEP_HI:   raddr = hi_m1[AW-1:0];
      ST_SWAP_LO: begin
        we    = swap;
        waddr = lo[AW-1:0];
        wdata = val_hi;
      end
      ST_SWAP_HI: begin
        // cached values were exchanged in the previous cycle
        we    = 1'b1;
        waddr = hi[AW-1:0];
        wdata = val_hi;
      end
      ST_STEP_LO:   raddr = lo_p1[AW-1:0];
      ST_EMIT_HOLD: raddr = k_p1;
      default:      raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_COLLECT;
      count        <= '0;
      lo           <= '0;
      hi           <= '0;
      k            <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_COLLECT: begin
          if (item_beat && (count < MAX_CNT)) begin
            count <= count + 1'b1;
          end
        end
        ST_INIT_LO: begin
          lo <= '0;
          hi <= count_m1;
        end
        ST_TEST:      k <= '0;
        ST_STEP_HI:   if (!val_hi[SIGN_BIT]) hi <= hi_m1;
        ST_STEP_LO:   if (val_lo[SIGN_BIT]) lo <= lo_p1;
        ST_EMIT_LOAD: result_valid <= 1'b1;
        ST_EMIT_HOLD: begin
          if (result_beat) begin
            result_valid <= 1'b0;
            if (last_out) begin
              count <= '0;
            end else begin
              k <= k_p1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_INIT_HI: val_lo <= rdata;
      ST_INIT_RD: val_hi <= rdata;
      ST_RD_HI:   val_hi <= rdata;
      ST_RD_LO:   val_lo <= rdata;
      ST_SWAP_LO: begin
        if (swap) begin
          val_lo <= val_hi;
          val_hi <= val_lo;
        end
      end
      ST_EMIT_LOAD: begin
        result_value <= rdata;
        last_out     <= (CW'(k) == count_m1);
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/spart_checker.sv =====
// Port-level checks for sign_partition_two_pointer, bound to the top level.
// Depends on sign_partition_two_pointer_defines.svh.
`default_nettype none

`include "sign_partition_two_pointer_defines.svh"

module spart_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        item_valid,
  input wire logic        item_stall,
  input wire logic [31:0] value,
  input wire logic        last_in,
  input wire logic        result_valid,
  input wire logic        result_stall,
  input wire logic [31:0] result_value,
  input wire logic        last_out
);

  // stalled result beat holds
  `SPART_ASSERT(a_result_hold, result_valid && result_stall |=> result_valid && $stable(result_value) && $stable(last_out))
  // no new set is loaded while results are going out
  `SPART_ASSERT(a_no_load_during_emit, result_valid |-> item_stall)
  // nothing follows the final beat of a set
  `SPART_ASSERT(a_last_ends_set, result_valid && !result_stall && last_out |=> !result_valid)
  // reset leaves the output empty
  `SPART_ASSERT_RST(a_reset_empty, rst |=> !result_valid)

endmodule

bind sign_partition_two_pointer spart_checker u_spart_checker (.*);

`default_nettype wire
